### sv/exp_ts_pkg.sv
package exp_ts_pkg;

    localparam int DEF_MAX_TERMS = 63;
    localparam int DEF_FRAC_BITS = 32;

    localparam int X_W        = 6;
    localparam int N_W        = 6;
    localparam int AX_W       = 5;
    localparam int SUM_W      = 64;
    localparam int MAG_W      = 64;
    localparam int RADIX_BITS = 8;

    localparam logic signed [X_W-1:0] X_LIMIT = 6'sd16;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

### sv/exp_taylor_series.sv
// Partial Taylor sum of e^x: for each item (x_value, term_count) returns the sum of x^k/k!
// for k = 0..n as a signed 64-bit fixed-point value with FRAC_BITS fraction bits. x_value is
// clamped to -16..16 and term_count to MAX_TERMS. Each term is floor(|term| * |x| / k) with
// the sign applied afterwards, and the sum saturates to the 64-bit range. One item is in work
// at a time; src_stall stays high from acceptance until the result has been taken. An item
// with n = 0 reaches its result in the cycle after acceptance. Otherwise each term passes
// through the states ST_MUL, ST_DIV and ST_ACC: a multiply on the shared 64x5 multiplier,
// a division on the shared divider that retires 8 quotient bits a cycle, and an accumulate
// step. The sequence ends early once a term truncates to zero.
module exp_taylor_series
    import exp_ts_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    src_valid,
    output logic                    src_stall,
    input  logic signed [X_W-1:0]   x_value,
    input  logic [N_W-1:0]          term_count,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic signed [SUM_W-1:0] series_sum
);

    localparam int KW          = $clog2(MAX_TERMS + 1);
    localparam int PW          = MAG_W + AX_W;
    localparam int DIV_CYCLES  = (PW + RADIX_BITS - 1) / RADIX_BITS;
    localparam int DW          = DIV_CYCLES * RADIX_BITS;
    localparam int DCW         = $clog2(DIV_CYCLES);

    state_t                    state_reg, state_next;
    logic [KW-1:0]             k_reg, k_next;
    logic [KW-1:0]             n_reg, n_next;
    logic [AX_W-1:0]           ax_reg, ax_next;
    logic                      neg_reg, neg_next;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [DW-1:0]             div_reg, div_next;
    logic [KW-1:0]             rem_reg, rem_next;
    logic [DCW-1:0]            dcnt_reg, dcnt_next;

    logic signed [X_W-1:0]     x_clamp;
    logic [AX_W-1:0]           ax_in;
    logic [KW-1:0]             n_in;
    logic [PW-1:0]             prod;
    logic [DW-1:0]             div_step;
    logic [KW-1:0]             rem_step;
    logic [MAG_W-1:0]          quot;
    logic signed [SUM_W-1:0]   term;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;

    assign src_stall  = (state_reg != ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign series_sum = sum_reg;

    always_comb
    begin
        if (x_value > X_LIMIT)
            x_clamp = X_LIMIT;
        else if (x_value < -X_LIMIT)
            x_clamp = -X_LIMIT;
        else
            x_clamp = x_value;
        ax_in = x_clamp[X_W-1] ? AX_W'(-x_clamp) : AX_W'(x_clamp);
        n_in  = (int'(term_count) > MAX_TERMS) ? KW'(MAX_TERMS) : KW'(term_count);
    end

    assign prod = {{AX_W{1'b0}}, mag_reg} * {{MAG_W{1'b0}}, ax_reg};

    // restoring division, RADIX_BITS quotient bits per cycle
    always_comb
    begin
        logic [KW:0]   sh;
        logic [KW-1:0] r;
        logic [DW-1:0] d;
        r = rem_reg;
        d = div_reg;
        for (int i = 0; i < RADIX_BITS; i++)
        begin
            sh = {r, d[DW-1]};
            d  = d << 1;
            if (sh >= {1'b0, k_reg})
            begin
                sh   = sh - {1'b0, k_reg};
                d[0] = 1'b1;
            end
            r = sh[KW-1:0];
        end
        div_step = d;
        rem_step = r;
    end

    assign quot = div_reg[MAG_W-1:0];

    always_comb
    begin
        term = $signed(quot);
        if (neg_reg && k_reg[0])
            term = -term;
        sum_wide = {sum_reg[SUM_W-1], sum_reg} + {term[SUM_W-1], term};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        ax_next    = ax_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        sum_next   = sum_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (src_valid)
                begin
                    ax_next    = ax_in;
                    neg_next   = x_clamp[X_W-1];
                    n_next     = n_in;
                    k_next     = KW'(1);
                    mag_next   = MAG_W'(1) << FRAC_BITS;
                    sum_next   = $signed(MAG_W'(1) << FRAC_BITS);
                    state_next = (n_in == '0) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_next   = DW'(prod);
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                div_next  = div_step;
                rem_next  = rem_step;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(DIV_CYCLES - 1))
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                mag_next = quot;
                if (quot == '0)
                    state_next = ST_DONE;
                else
                begin
                    sum_next = sum_sat;
                    if (k_reg == n_reg)
                        state_next = ST_DONE;
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DONE:
            begin
                if (!res_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        n_reg    <= n_next;
        ax_reg   <= ax_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        sum_reg  <= sum_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
    end

endmodule

### sv/exp_ts_chk.sv
module exp_ts_chk
    import exp_ts_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    src_valid,
    input logic                    src_stall,
    input logic                    res_valid,
    input logic                    res_stall,
    input logic signed [SUM_W-1:0] series_sum
);

    // hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(series_sum))
        else $error("stalled result changed");

    // go busy after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> src_stall)
        else $error("ready right after accepting an item");

    // no result pending while ready
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !src_stall |-> !res_valid)
        else $error("result pending while ready");

    // drop the result once taken
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall |=> !res_valid)
        else $error("result repeated");

endmodule

bind exp_taylor_series exp_ts_chk u_exp_ts_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .series_sum (series_sum)
);

### bench/exp_taylor_series_tb.sv
module exp_taylor_series_tb;
    import exp_ts_pkg::*;

    localparam int MAX_TERMS = DEF_MAX_TERMS;
    localparam int FRAC_BITS = DEF_FRAC_BITS;
    localparam int RANDOM_ITEMS = 1450;
    localparam int CALM_ITEMS = 150;
    localparam int PAUSE_AT = 700;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DIR_ROWS = 24;
    localparam logic signed [SUM_W-1:0] FIX_ONE = 64'sd1 <<< FRAC_BITS;

    typedef struct {
        logic signed [X_W-1:0]   x;
        logic [N_W-1:0]          n;
        bit                      fixed;
        logic signed [SUM_W-1:0] sum;
    } stim_row_t;

    typedef struct {
        logic signed [X_W-1:0]   x;
        logic [N_W-1:0]          n;
        logic signed [SUM_W-1:0] sum;
    } sum_exp_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    src_valid;
    logic                    src_stall;
    logic signed [X_W-1:0]   x_value;
    logic [N_W-1:0]          term_count;
    logic                    res_valid;
    logic                    res_stall;
    logic signed [SUM_W-1:0] series_sum;

    sum_exp_t  sum_q[$];
    stim_row_t dir_table [DIR_ROWS];
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        idle_on = 1'b1;
    int        stall_left;

    exp_taylor_series u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .x_value    (x_value),
        .term_count (term_count),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .series_sum (series_sum)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [SUM_W-1:0] taylor_sum(
        input logic signed [X_W-1:0] xv,
        input logic [N_W-1:0]        nv
    );
        int                      xi;
        int unsigned             last_k;
        logic [MAG_W-1:0]        ax;
        logic [MAG_W-1:0]        mag;
        logic [MAG_W-1:0]        q;
        logic [MAG_W-1:0]        r;
        logic [MAG_W-1:0]        kk;
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] term;
        logic signed [SUM_W:0]   wide;
        bit                      neg;
        bit                      done;
        xi = int'(xv);
        if (xi > 16)
            xi = 16;
        if (xi < -16)
            xi = -16;
        last_k = 32'(nv);
        if (last_k > MAX_TERMS)
            last_k = MAX_TERMS;
        neg = xi < 0;
        ax = neg ? 64'(-xi) : 64'(xi);
        mag = 64'd1 << FRAC_BITS;
        acc = mag;
        done = 1'b0;
        for (int unsigned k = 1; k <= last_k && !done; k++)
        begin
            kk = 64'(k);
            q = mag / kk;
            r = mag % kk;
            mag = q * ax + (r * ax) / kk;
            if (mag == '0)
                done = 1'b1;
            else
            begin
                term = mag;
                if (neg && kk[0])
                    term = -term;
                wide = $signed({acc[SUM_W-1], acc}) + $signed({term[SUM_W-1], term});
                if (wide[SUM_W] != wide[SUM_W-1])
                    acc = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
                else
                    acc = wide[SUM_W-1:0];
            end
        end
        return acc;
    endfunction

    task automatic send_item(
        input logic signed [X_W-1:0]   xv,
        input logic [N_W-1:0]          nv,
        input bit                      fixed,
        input logic signed [SUM_W-1:0] fixed_sum
    );
        sum_exp_t e;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        src_valid  <= 1'b1;
        x_value    <= xv;
        term_count <= nv;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        e.x = xv;
        e.n = nv;
        e.sum = fixed ? fixed_sum : taylor_sum(xv, nv);
        sum_q.push_back(e);
    endtask

    // random receiver stall in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (!idle_on)
            res_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 14) - 1;
        end
        else
            res_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        sum_exp_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (sum_q.size() == 0)
            begin
                $display("%0t: unexpected item, series_sum %0d, expected none",
                         $time, series_sum);
                fail_count++;
            end
            else
            begin
                e = sum_q.pop_front();
                if (series_sum !== e.sum)
                begin
                    $display("%0t: series_sum mismatch (x=%0d n=%0d): expected %0d, got %0d",
                             $time, e.x, e.n, e.sum, series_sum);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic signed [X_W-1:0] xr;
        logic [N_W-1:0]        nr;
        int                    pick;

        dir_table = '{
            '{6'sd0,   6'd0,  1'b1, FIX_ONE},
            '{6'sd0,   6'd63, 1'b1, FIX_ONE},
            '{6'sd16,  6'd0,  1'b1, FIX_ONE},
            '{-6'sd16, 6'd0,  1'b1, FIX_ONE},
            '{6'sd1,   6'd1,  1'b1, FIX_ONE * 2},
            '{-6'sd1,  6'd1,  1'b1, 64'sd0},
            '{6'sd16,  6'd1,  1'b1, FIX_ONE * 17},
            '{-6'sd16, 6'd1,  1'b1, -(FIX_ONE * 15)},
            '{6'sd31,  6'd1,  1'b1, FIX_ONE * 17},
            '{-6'sd32, 6'd1,  1'b1, -(FIX_ONE * 15)},
            '{6'sd17,  6'd1,  1'b1, FIX_ONE * 17},
            '{-6'sd17, 6'd1,  1'b1, -(FIX_ONE * 15)},
            '{6'sd2,   6'd2,  1'b1, FIX_ONE * 5},
            '{6'sd16,  6'd63, 1'b0, 64'sd0},
            '{-6'sd16, 6'd63, 1'b0, 64'sd0},
            '{6'sd1,   6'd63, 1'b0, 64'sd0},
            '{-6'sd1,  6'd63, 1'b0, 64'sd0},
            '{6'sd31,  6'd63, 1'b0, 64'sd0},
            '{-6'sd32, 6'd63, 1'b0, 64'sd0},
            '{6'sd5,   6'd10, 1'b0, 64'sd0},
            '{-6'sd7,  6'd20, 1'b0, 64'sd0},
            '{6'sd3,   6'd32, 1'b0, 64'sd0},
            '{-6'sd5,  6'd31, 1'b0, 64'sd0},
            '{6'sd10,  6'd42, 1'b0, 64'sd0}
        };

        rst_n      <= 1'b0;
        src_valid  <= 1'b0;
        x_value    <= '0;
        term_count <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            send_item(dir_table[i].x, dir_table[i].n, dir_table[i].fixed, dir_table[i].sum);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            if (i == PAUSE_AT)
            begin
                // hold off until the block has returned everything
                src_valid <= 1'b0;
                while (sum_q.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 9) == 0)
                xr = X_W'($urandom_range(0, 63));
            else
                xr = $signed(6'($urandom_range(0, 32))) - 6'sd16;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                nr = N_W'($urandom_range(0, 20));
            else if (pick < 95)
                nr = N_W'($urandom_range(21, 40));
            else
                nr = N_W'($urandom_range(41, 63));
            send_item(xr, nr, 1'b0, 64'sd0);
        end
        src_valid <= 1'b0;

        while (sum_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/exp_ts_pkg.sv
sv/exp_taylor_series.sv
sv/exp_ts_chk.sv
bench/exp_taylor_series_tb.sv
